FILE: rtl/m3rb_pkg.sv
// ----------------------------------------------------------------------------
// m3rb_pkg
// Shared constants, codes and types of the 3x3 mask correlation block with
// replicated image borders.
// ----------------------------------------------------------------------------
package m3rb_pkg;

   // default geometry and arithmetic widths
   localparam int MAX_WIDTH_DEF   = 1024;
   localparam int MAX_HEIGHT_DEF  = 4096;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COEF_BITS_DEF   = 16;

   // mask size: taps per row and per column
   localparam int TAPS = 3;

   // register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_MIN   = 48;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COEF_TOP     = 3'd0,
      CSR_COEF_MID     = 3'd1,
      CSR_COEF_BOT     = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   // results caused by one sample, in the order they leave the block
   typedef enum logic [1:0] {
      SLOT_PREV_LEFT = 2'd0,   // previous row, one column behind
      SLOT_PREV_EDGE = 2'd1,   // previous row, right image edge
      SLOT_LAST_LEFT = 2'd2,   // last row itself, one column behind
      SLOT_LAST_EDGE = 2'd3    // last row itself, right image edge
   } slot_type;

   // window tap selection codes
   typedef logic [1:0] tap_sel_type;

   localparam tap_sel_type ROW_OLDER   = 2'd0;
   localparam tap_sel_type ROW_NEWER   = 2'd1;
   localparam tap_sel_type ROW_CURRENT = 2'd2;

   localparam tap_sel_type COL_LEFT  = 2'd0;
   localparam tap_sel_type COL_MID   = 2'd1;
   localparam tap_sel_type COL_RIGHT = 2'd2;

   // tap selection and framing flags of one result
   typedef struct packed {
      tap_sel_type [TAPS-1:0] rsel;
      tap_sel_type [TAPS-1:0] csel;
      logic                   run_end;
      logic                   frame_end;
   } result_tag_type;

endpackage

FILE: rtl/m3rb_if.sv
// ----------------------------------------------------------------------------
// m3rb channel interfaces
// Sample input channel, result output channel and register write channel.
// ----------------------------------------------------------------------------
interface m3rb_req_if import m3rb_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface m3rb_rsp_if import m3rb_pkg::*; #(
   parameter int SUM_BITS = SAMPLE_BITS_DEF + COEF_BITS_DEF + 3,
   parameter int ROW_BITS = $clog2(MAX_HEIGHT_DEF),
   parameter int COL_BITS = $clog2(MAX_WIDTH_DEF)
);
   logic                       valid;
   logic                       ready;
   logic signed [SUM_BITS-1:0] value;
   logic [ROW_BITS-1:0]        out_row;
   logic [COL_BITS-1:0]        out_col;
   logic                       run_end;
   logic                       frame_end;

   modport source (output valid, output value, output out_row, output out_col,
                   output run_end, output frame_end, input ready);
   modport sink   (input valid, input value, input out_row, input out_col,
                   input run_end, input frame_end, output ready);
endinterface

interface m3rb_csr_if import m3rb_pkg::*; #(
   parameter int DATA_BITS = CSR_DATA_MIN
);
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DATA_BITS-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/m3rb_ram.sv
// ----------------------------------------------------------------------------
// m3rb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module m3rb_ram #(
   parameter int  WIDTH     = 16,
   parameter int  DEPTH     = 1024,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/m3rb_col_cell.sv
// ----------------------------------------------------------------------------
// m3rb_col_cell
// One column of the 3x3 window; loads its neighbor's column on each shift.
// ----------------------------------------------------------------------------
module m3rb_col_cell import m3rb_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          shift,
   input  logic signed [SAMPLE_BITS-1:0] in_taps  [TAPS],
   output logic signed [SAMPLE_BITS-1:0] out_taps [TAPS]
);

   logic signed [SAMPLE_BITS-1:0] taps_ff [TAPS];

   // take the column from the right-hand neighbor
   always_ff @(posedge clock) begin
      if (shift) begin
         for (int k = 0; k < TAPS; k++) begin
            taps_ff[k] <= in_taps[k];
         end
      end
   end

   assign out_taps = taps_ff;

endmodule

FILE: rtl/m3rb_mac.sv
// ----------------------------------------------------------------------------
// m3rb_mac
// Three-stage multiply-add pipeline: nine products, three row sums, total.
// ----------------------------------------------------------------------------
module m3rb_mac import m3rb_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF,
   parameter int ROW_BITS    = $clog2(MAX_HEIGHT_DEF),
   parameter int COL_BITS    = $clog2(MAX_WIDTH_DEF)
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       in_valid,
   output logic                                       in_ready,
   input  result_tag_type                             in_tag,
   input  logic [ROW_BITS-1:0]                        in_row,
   input  logic [COL_BITS-1:0]                        in_col,
   input  logic signed [SAMPLE_BITS-1:0]              win [TAPS][TAPS],
   input  logic [TAPS*COEF_BITS-1:0]                  coef_rows [TAPS],
   output logic                                       out_valid,
   input  logic                                       out_ready,
   output logic signed [SAMPLE_BITS+COEF_BITS+2:0]    out_value,
   output logic [ROW_BITS-1:0]                        out_row,
   output logic [COL_BITS-1:0]                        out_col,
   output logic                                       out_run_end,
   output logic                                       out_frame_end
);

   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int RSUM_BITS = PROD_BITS + 2;
   localparam int SUM_BITS  = PROD_BITS + 3;

   logic signed [SAMPLE_BITS-1:0] row_pick [TAPS][TAPS];
   logic signed [SAMPLE_BITS-1:0] tap      [TAPS][TAPS];
   logic signed [COEF_BITS-1:0]   coef     [TAPS][TAPS];
   logic signed [PROD_BITS-1:0]   prod_in  [TAPS][TAPS];
   logic signed [RSUM_BITS-1:0]   rsum_in  [TAPS];
   logic signed [SUM_BITS-1:0]    sum_in;

   logic                          v1_ff, v2_ff, v3_ff;
   logic                          v1_in, v2_in, v3_in;
   logic                          rdy2, rdy3;

   logic signed [PROD_BITS-1:0]   prod_ff [TAPS][TAPS];
   logic signed [RSUM_BITS-1:0]   rsum_ff [TAPS];
   logic signed [SUM_BITS-1:0]    sum_ff;
   result_tag_type                tag1_ff, tag2_ff, tag3_ff;
   logic [ROW_BITS-1:0]           row1_ff, row2_ff, row3_ff;
   logic [COL_BITS-1:0]           col1_ff, col2_ff, col3_ff;

   // stall chain: a stage loads when it is empty or drains this cycle
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = !v1_ff || rdy2;

   assign v1_in = in_ready ? in_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   // pick the window taps of this result and multiply by the mask
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         for (int j = 0; j < TAPS; j++) begin
            case (in_tag.rsel[k])
               ROW_OLDER: row_pick[k][j] = win[j][0];
               ROW_NEWER: row_pick[k][j] = win[j][1];
               default:   row_pick[k][j] = win[j][2];
            endcase
         end
      end
      for (int k = 0; k < TAPS; k++) begin
         for (int l = 0; l < TAPS; l++) begin
            case (in_tag.csel[l])
               COL_LEFT: tap[k][l] = row_pick[k][0];
               COL_MID:  tap[k][l] = row_pick[k][1];
               default:  tap[k][l] = row_pick[k][2];
            endcase
            coef[k][l]    = $signed(coef_rows[k][l*COEF_BITS +: COEF_BITS]);
            prod_in[k][l] = tap[k][l] * coef[k][l];
         end
      end
   end

   // sum each mask row, then the three row sums
   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         rsum_in[k] = RSUM_BITS'(prod_ff[k][0]) + RSUM_BITS'(prod_ff[k][1])
                    + RSUM_BITS'(prod_ff[k][2]);
      end
      sum_in = SUM_BITS'(rsum_ff[0]) + SUM_BITS'(rsum_ff[1]) + SUM_BITS'(rsum_ff[2]);
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage payloads, advance only when the stage loads
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
         tag1_ff <= in_tag;
         row1_ff <= in_row;
         col1_ff <= in_col;
      end
      if (rdy2 && v1_ff) begin
         rsum_ff <= rsum_in;
         tag2_ff <= tag1_ff;
         row2_ff <= row1_ff;
         col2_ff <= col1_ff;
      end
      if (rdy3 && v2_ff) begin
         sum_ff  <= sum_in;
         tag3_ff <= tag2_ff;
         row3_ff <= row2_ff;
         col3_ff <= col2_ff;
      end
   end

   assign out_valid     = v3_ff;
   assign out_value     = sum_ff;
   assign out_row       = row3_ff;
   assign out_col       = col3_ff;
   assign out_run_end   = tag3_ff.run_end;
   assign out_frame_end = tag3_ff.frame_end;

endmodule

FILE: rtl/mask3x3_replicate_border_top.sv
// ----------------------------------------------------------------------------
// mask3x3_replicate_border_top
// 3x3 mask correlation over a raster-order sample stream, borders replicated.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one signed sample per transaction in raster order.
//   rsp_chan carries one result per transaction: the exact signed weighted sum,
//   its row and column, run_end on the last result caused by a sample and
//   frame_end on the final result of the image.
//   csr_chan writes the three mask rows, image_width and image_height; it is
//   always ready. Write it only while no image is in flight.
//   Results of row i appear while row i+1 streams in, one column behind; the
//   last row also yields its own results, so a last-row sample past the
//   first column yields two and the final sample four.
//   Throughput: one sample per cycle while rsp_chan does not stall; a sample
//   that yields two or four results holds the next sample back until they
//   have issued, since the single multiply-add pipeline takes one result
//   per cycle.
//   A sample reaches its first result through the input register, window
//   shift, products, row sums and output register.
//   When rsp_chan stalls, results wait in the pipeline and req_chan stalls
//   once the pipeline, the result scheduler and the input register are full.
//   Reset clears counters, coefficients and pipeline valids; the line stores
//   need no clearing, as no result uses an entry before it holds image data.
// ----------------------------------------------------------------------------
module mask3x3_replicate_border_top import m3rb_pkg::*; #(
   parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = COEF_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   m3rb_req_if.sink      req_chan,
   m3rb_rsp_if.source    rsp_chan,
   m3rb_csr_if.sink      csr_chan
);

   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int WREG_BITS     = $clog2(MAX_WIDTH + 1);
   localparam int HREG_BITS     = $clog2(MAX_HEIGHT + 1);
   localparam int COEF_ROW_BITS = TAPS * COEF_BITS;
   localparam int SUM_BITS      = SAMPLE_BITS + COEF_BITS + 3;

   // configuration registers
   logic [COEF_ROW_BITS-1:0]      coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [WREG_BITS-1:0]          width_ff;
   logic [HREG_BITS-1:0]          height_ff;
   logic [COEF_ROW_BITS-1:0]      coef_rows [TAPS];

   // geometry and position
   logic [COL_BITS-1:0]           wlast, c_pos, col_ff, col_in;
   logic [ROW_BITS-1:0]           hlast, r_pos, row_ff, row_in;
   logic                          c_last, r_last;
   logic                          req_fire;

   // input register
   logic                          s1_valid_ff, s1_valid_in, s1_adv;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [COL_BITS-1:0]           s1_col_ff;
   logic [ROW_BITS-1:0]           s1_row_ff;
   logic                          s1_c_zero_ff, s1_c_last_ff, s1_c_one_ff;
   logic                          s1_r_zero_ff, s1_r_last_ff, s1_r_one_ff;

   // line stores and window
   logic signed [SAMPLE_BITS-1:0] older_rd, newer_rd;
   logic signed [SAMPLE_BITS-1:0] head_taps [TAPS];
   logic signed [SAMPLE_BITS-1:0] win [TAPS][TAPS];

   // result scheduler
   logic [3:0]                    s2_mask_ff, s2_mask_in, mask_rest;
   logic [ROW_BITS-1:0]           s2_row_ff;
   logic [COL_BITS-1:0]           s2_col_ff;
   logic                          s2_r_one_ff, s2_c_one_ff;
   logic                          s2_busy, s2_load_ok, issue_fire;
   slot_type                      slot;
   logic                          pass_last, at_edge;
   result_tag_type                issue_tag;
   logic [ROW_BITS-1:0]           issue_row;
   logic [COL_BITS-1:0]           issue_col;
   logic                          mac_ready;

   // register writes
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= '0;
         coef_mid_ff <= '0;
         coef_bot_ff <= '0;
         width_ff    <= WREG_BITS'(MAX_WIDTH);
         height_ff   <= HREG_BITS'(MAX_HEIGHT);
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_COEF_TOP:     coef_top_ff <= csr_chan.data[COEF_ROW_BITS-1:0];
            CSR_COEF_MID:     coef_mid_ff <= csr_chan.data[COEF_ROW_BITS-1:0];
            CSR_COEF_BOT:     coef_bot_ff <= csr_chan.data[COEF_ROW_BITS-1:0];
            CSR_IMAGE_WIDTH:  width_ff    <= csr_chan.data[WREG_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff   <= csr_chan.data[HREG_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign coef_rows[0] = coef_top_ff;
   assign coef_rows[1] = coef_mid_ff;
   assign coef_rows[2] = coef_bot_ff;

   // clamp geometry to the supported range
   always_comb begin
      if (width_ff < WREG_BITS'(2)) begin
         wlast = COL_BITS'(1);
      end else if (width_ff > WREG_BITS'(MAX_WIDTH)) begin
         wlast = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         wlast = COL_BITS'(width_ff - WREG_BITS'(1));
      end
      if (height_ff < HREG_BITS'(2)) begin
         hlast = ROW_BITS'(1);
      end else if (height_ff > HREG_BITS'(MAX_HEIGHT)) begin
         hlast = ROW_BITS'(MAX_HEIGHT - 1);
      end else begin
         hlast = ROW_BITS'(height_ff - HREG_BITS'(1));
      end
   end

   // position of the incoming sample, held inside the image
   assign c_pos  = (col_ff < wlast) ? col_ff : wlast;
   assign r_pos  = (row_ff < hlast) ? row_ff : hlast;
   assign c_last = (c_pos == wlast);
   assign r_last = (r_pos == hlast);

   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // advance raster counters on each accepted transaction
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_fire) begin
         if (c_last) begin
            col_in = '0;
            row_in = r_last ? '0 : r_pos + ROW_BITS'(1);
         end else begin
            col_in = c_pos + COL_BITS'(1);
            row_in = r_pos;
         end
      end
   end

   // input register stage
   assign s1_adv      = s1_valid_ff && s2_load_ok;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_sample_ff <= req_chan.sample;
         s1_col_ff    <= c_pos;
         s1_row_ff    <= r_pos;
         s1_c_zero_ff <= (c_pos == '0);
         s1_c_last_ff <= c_last;
         s1_c_one_ff  <= (c_pos == COL_BITS'(1));
         s1_r_zero_ff <= (r_pos == '0);
         s1_r_last_ff <= r_last;
         s1_r_one_ff  <= (r_pos == ROW_BITS'(1));
      end
   end

   // line stores: read on accept, rotate rows when the window shifts
   m3rb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_older_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (newer_rd),
      .rd_en   (req_fire),
      .rd_addr (c_pos),
      .rd_data (older_rd)
   );

   m3rb_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_newer_store (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (req_fire),
      .rd_addr (c_pos),
      .rd_data (newer_rd)
   );

   // window: chain of column cells, newest column enters on the right
   assign head_taps[0] = older_rd;
   assign head_taps[1] = newer_rd;
   assign head_taps[2] = s1_sample_ff;

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      if (i == TAPS - 1) begin : g_head
         m3rb_col_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_cell (
            .clock    (clock),
            .shift    (s1_adv),
            .in_taps  (head_taps),
            .out_taps (win[i])
         );
      end else begin : g_body
         m3rb_col_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
         ) u_cell (
            .clock    (clock),
            .shift    (s1_adv),
            .in_taps  (win[i+1]),
            .out_taps (win[i])
         );
      end
   end

   // pick the next pending result, lowest slot first
   always_comb begin
      slot = SLOT_LAST_EDGE;
      if (s2_mask_ff[SLOT_PREV_LEFT]) begin
         slot = SLOT_PREV_LEFT;
      end else if (s2_mask_ff[SLOT_PREV_EDGE]) begin
         slot = SLOT_PREV_EDGE;
      end else if (s2_mask_ff[SLOT_LAST_LEFT]) begin
         slot = SLOT_LAST_LEFT;
      end
      mask_rest       = s2_mask_ff;
      mask_rest[slot] = 1'b0;
   end

   assign s2_busy    = (s2_mask_ff != '0);
   assign issue_fire = s2_busy && mac_ready;
   assign s2_load_ok = !s2_busy || (issue_fire && (mask_rest == '0));

   // load the pending set on a shift, drop each result as it issues
   always_comb begin
      s2_mask_in = s2_mask_ff;
      if (s1_adv) begin
         s2_mask_in[SLOT_PREV_LEFT] = !s1_r_zero_ff && !s1_c_zero_ff;
         s2_mask_in[SLOT_PREV_EDGE] = !s1_r_zero_ff && s1_c_last_ff;
         s2_mask_in[SLOT_LAST_LEFT] = s1_r_last_ff && !s1_c_zero_ff;
         s2_mask_in[SLOT_LAST_EDGE] = s1_r_last_ff && s1_c_last_ff;
      end else if (issue_fire) begin
         s2_mask_in = mask_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
      end else begin
         s2_mask_ff <= s2_mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_row_ff   <= s1_row_ff;
         s2_col_ff   <= s1_col_ff;
         s2_r_one_ff <= s1_r_one_ff;
         s2_c_one_ff <= s1_c_one_ff;
      end
   end

   // tap selection, position and framing of the issued result
   assign pass_last = (slot == SLOT_LAST_LEFT) || (slot == SLOT_LAST_EDGE);
   assign at_edge   = (slot == SLOT_PREV_EDGE) || (slot == SLOT_LAST_EDGE);

   always_comb begin
      if (pass_last) begin
         issue_tag.rsel[0] = ROW_NEWER;
         issue_tag.rsel[1] = ROW_CURRENT;
         issue_row         = s2_row_ff;
      end else begin
         issue_tag.rsel[0] = s2_r_one_ff ? ROW_NEWER : ROW_OLDER;
         issue_tag.rsel[1] = ROW_NEWER;
         issue_row         = s2_row_ff - ROW_BITS'(1);
      end
      issue_tag.rsel[2] = ROW_CURRENT;
      if (at_edge) begin
         issue_tag.csel[0] = COL_MID;
         issue_tag.csel[1] = COL_RIGHT;
         issue_col         = s2_col_ff;
      end else begin
         issue_tag.csel[0] = s2_c_one_ff ? COL_MID : COL_LEFT;
         issue_tag.csel[1] = COL_MID;
         issue_col         = s2_col_ff - COL_BITS'(1);
      end
      issue_tag.csel[2]   = COL_RIGHT;
      issue_tag.run_end   = (mask_rest == '0);
      issue_tag.frame_end = (slot == SLOT_LAST_EDGE);
   end

   // multiply-add pipeline with the output register
   m3rb_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ROW_BITS    (ROW_BITS),
      .COL_BITS    (COL_BITS)
   ) u_mac (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s2_busy),
      .in_ready      (mac_ready),
      .in_tag        (issue_tag),
      .in_row        (issue_row),
      .in_col        (issue_col),
      .win           (win),
      .coef_rows     (coef_rows),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .out_value     (rsp_chan.value),
      .out_row       (rsp_chan.out_row),
      .out_col       (rsp_chan.out_col),
      .out_run_end   (rsp_chan.run_end),
      .out_frame_end (rsp_chan.frame_end)
   );

endmodule
